// ===== src/fcsb_pkg.sv =====
// ----------------------------------------------------------------------------
// fcsb_pkg
// Types and constants shared by the frustum sphere/box cull pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package fcsb_pkg;

    localparam int PLANE_COUNT = 6;
    localparam int SIDE_PLANES = 4;
    localparam int AXES        = 3;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int COORD_W     = 16;
    localparam int RADIUS_W    = 15;
    localparam int PROD_W      = 32;
    localparam int PAIR_W      = 33;
    localparam int SUM_W       = 35;
    localparam int FRAC_SHIFT  = 14;

    typedef enum logic [CFG_INDEX_W-1:0] {
        PLANE_RIGHT  = 3'd0,
        PLANE_LEFT   = 3'd1,
        PLANE_TOP    = 3'd2,
        PLANE_BOTTOM = 3'd3,
        PLANE_FAR    = 3'd4,
        PLANE_NEAR   = 3'd5
    } plane_index_t;

    typedef struct packed {
        logic                       func;
        logic                       skip_depth_planes;
        logic signed [COORD_W-1:0]  ax;
        logic signed [COORD_W-1:0]  ay;
        logic signed [COORD_W-1:0]  az;
        logic signed [COORD_W-1:0]  bx;
        logic signed [COORD_W-1:0]  by;
        logic signed [COORD_W-1:0]  bz;
        logic        [RADIUS_W-1:0] radius;
        logic                       last_in;
    } in_beat_t;

    typedef struct packed {
        logic culled;
        logic last_out;
    } out_beat_t;

    function automatic logic signed [COORD_W-1:0] plane_field(
        input logic [CFG_DATA_W-1:0] p,
        input int unsigned           k
    );
        plane_field = $signed(p[COORD_W*k +: COORD_W]);
    endfunction

endpackage

`default_nettype wire

// ===== src/frustum_cull_sphere_box.sv =====
// Each accepted input beat is registered in stages 1 (multiply), 2 (axis max and
// pair add), 3 (plane sum and compare) and 4 (plane OR, the output register).
// Throughput: one beat per cycle while the output is not stalled.
// A stalled output holds its stage; empty stages upstream still fill.
// Reset: all stage valid bits clear and all six planes read zero.
// ----------------------------------------------------------------------------
// frustum_cull_sphere_box
// Culls spheres and axis-aligned boxes against six configurable planes.
// ----------------------------------------------------------------------------
`default_nettype none

module frustum_cull_sphere_box
    import fcsb_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output      logic                   in_stall,
    input  wire in_beat_t               in_data,
    output      logic                   out_valid,
    input  wire logic                   out_stall,
    output      out_beat_t              out_data,
    input  wire logic                   cfg_valid,
    output      logic                   cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [CFG_DATA_W-1:0] plane_reg [PLANE_COUNT];

    logic en1, en2, en3, en4;

    logic                       s1_valid_reg;
    logic                       s1_func_reg;
    logic                       s1_skip_reg;
    logic                       s1_last_reg;
    logic        [RADIUS_W-1:0] s1_radius_reg;
    logic signed [PROD_W-1:0]   s1_pa_reg [PLANE_COUNT][AXES];
    logic signed [PROD_W-1:0]   s1_pb_reg [PLANE_COUNT][AXES];
    logic signed [PROD_W-1:0]   s1_pa_next [PLANE_COUNT][AXES];
    logic signed [PROD_W-1:0]   s1_pb_next [PLANE_COUNT][AXES];

    logic                       s2_valid_reg;
    logic                       s2_func_reg;
    logic                       s2_skip_reg;
    logic                       s2_last_reg;
    logic        [RADIUS_W-1:0] s2_radius_reg;
    logic signed [PAIR_W-1:0]   s2_xy_reg [PLANE_COUNT];
    logic signed [PROD_W-1:0]   s2_z_reg [PLANE_COUNT];
    logic signed [PAIR_W-1:0]   s2_xy_next [PLANE_COUNT];
    logic signed [PROD_W-1:0]   s2_z_next [PLANE_COUNT];

    logic                       s3_valid_reg;
    logic                       s3_skip_reg;
    logic                       s3_last_reg;
    logic [PLANE_COUNT-1:0]     s3_cull_reg;
    logic [PLANE_COUNT-1:0]     s3_cull_next;

    logic                       out_valid_reg;
    out_beat_t                  out_data_reg;
    out_beat_t                  out_data_next;

    assign en4       = !out_valid_reg || !out_stall;
    assign en3       = !s3_valid_reg || en4;
    assign en2       = !s2_valid_reg || en3;
    assign en1       = !s1_valid_reg || en2;
    assign in_stall  = !en1;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PLANE_COUNT; i++)
            begin
                plane_reg[i] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            for (int i = 0; i < PLANE_COUNT; i++)
            begin
                if (cfg_index == CFG_INDEX_W'(i))
                begin
                    plane_reg[i] <= cfg_data;
                end
            end
        end
    end

    // stage 1: products of min and max corners (or the sphere centre) with each plane normal
    always_comb
    begin
        logic signed [COORD_W-1:0] ca [AXES];
        logic signed [COORD_W-1:0] cb [AXES];
        ca[0] = in_data.ax;
        ca[1] = in_data.ay;
        ca[2] = in_data.az;
        cb[0] = in_data.bx;
        cb[1] = in_data.by;
        cb[2] = in_data.bz;
        for (int i = 0; i < PLANE_COUNT; i++)
        begin
            for (int k = 0; k < AXES; k++)
            begin
                s1_pa_next[i][k] = ca[k] * plane_field(plane_reg[i], k);
                s1_pb_next[i][k] = cb[k] * plane_field(plane_reg[i], k);
            end
        end
    end

    // stage 2: per-axis max for boxes, then add x and y
    always_comb
    begin
        logic signed [PROD_W-1:0] m [AXES];
        for (int i = 0; i < PLANE_COUNT; i++)
        begin
            for (int k = 0; k < AXES; k++)
            begin
                if (s1_func_reg && (s1_pb_reg[i][k] > s1_pa_reg[i][k]))
                begin
                    m[k] = s1_pb_reg[i][k];
                end
                else
                begin
                    m[k] = s1_pa_reg[i][k];
                end
            end
            s2_xy_next[i] = PAIR_W'(m[0]) + PAIR_W'(m[1]);
            s2_z_next[i]  = m[2];
        end
    end

    // stage 3: full plane sum with aligned offset and, for spheres, radius; test against zero
    always_comb
    begin
        logic signed [SUM_W-1:0] d_al;
        logic signed [SUM_W-1:0] r_al;
        logic signed [SUM_W-1:0] total;
        r_al = s2_func_reg ? '0
                           : $signed({{(SUM_W-RADIUS_W-FRAC_SHIFT){1'b0}},
                                      s2_radius_reg, {FRAC_SHIFT{1'b0}}});
        for (int i = 0; i < PLANE_COUNT; i++)
        begin
            d_al  = SUM_W'(plane_field(plane_reg[i], AXES)) <<< FRAC_SHIFT;
            total = SUM_W'(s2_xy_reg[i]) + SUM_W'(s2_z_reg[i]) + d_al + r_al;
            s3_cull_next[i] = (total <= 0);
        end
    end

    // stage 4: combine the tested planes
    always_comb
    begin
        out_data_next.culled   = (|s3_cull_reg[SIDE_PLANES-1:0])
                               || (!s3_skip_reg
                                   && (|s3_cull_reg[PLANE_COUNT-1:SIDE_PLANES]));
        out_data_next.last_out = s3_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (en4)
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && in_valid)
        begin
            s1_func_reg   <= in_data.func;
            s1_skip_reg   <= in_data.skip_depth_planes;
            s1_last_reg   <= in_data.last_in;
            s1_radius_reg <= in_data.radius;
            s1_pa_reg     <= s1_pa_next;
            s1_pb_reg     <= s1_pb_next;
        end
        if (en2 && s1_valid_reg)
        begin
            s2_func_reg   <= s1_func_reg;
            s2_skip_reg   <= s1_skip_reg;
            s2_last_reg   <= s1_last_reg;
            s2_radius_reg <= s1_radius_reg;
            s2_xy_reg     <= s2_xy_next;
            s2_z_reg      <= s2_z_next;
        end
        if (en3 && s2_valid_reg)
        begin
            s3_skip_reg <= s2_skip_reg;
            s3_last_reg <= s2_last_reg;
            s3_cull_reg <= s3_cull_next;
        end
        if (en4 && s3_valid_reg)
        begin
            out_data_reg <= out_data_next;
        end
    end

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && s2_valid_reg && s3_valid_reg
                      && out_valid_reg && out_stall))
        else $error("input stalled while pipeline has room");

    a_accept_fills_stage1: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> s1_valid_reg)
        else $error("accepted beat missing from stage 1");

    a_drain_empties_output: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !s3_valid_reg) |=> !out_valid)
        else $error("output beat repeated after delivery");

endmodule

`default_nettype wire
